/* sv/assert_macros.svh */
// Assertion macros shared by the camera-view RTL.
// No dependencies; the clock and reset are taken as clk_i and rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

/* sv/fcvu_pkg.sv */
// Shared types, constants and tables for the camera view update core.
// No dependencies.
`timescale 1ns / 1ps
package fcvu_pkg;

  // angles in units of 2^-16 degree
  localparam logic signed [25:0] DEG_90      = 26'sd5898240;
  localparam logic signed [25:0] DEG_180     = 26'sd11796480;
  localparam logic signed [25:0] YAW_RESET   = -26'sd5898240;
  localparam logic signed [35:0] PITCH_MAX   = 36'sd5242880;
  localparam logic signed [36:0] YAW_BIAS    = 37'sd11796480;
  localparam logic signed [36:0] DEG_360_W   = 37'sd23592960;
  localparam logic signed [36:0] DEG_360_K   = 37'sd24159191040; // 360 deg * 1024
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic        [3:0]  CORDIC_LAST = 4'd15;
  localparam logic        [3:0]  YAW_MOD_TOP = 4'd10;
  localparam logic signed [53:0] POS_MAX     = 54'sd140737488355327;
  localparam logic signed [53:0] POS_MIN     = -54'sd140737488355328;

  localparam logic [1:0] CFG_SPEED_LEVEL = 2'd0;
  localparam logic [1:0] CFG_SPACE_MODE  = 2'd1;
  localparam logic [1:0] CFG_CENTER_X    = 2'd2;
  localparam logic [1:0] CFG_CENTER_Y    = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_TURN, OP_YAW_PREP, OP_YAW_MOD, OP_PITCH,
    OP_C_INIT, OP_C_ITER, OP_C_DONE, OP_PROD, OP_SPEED, OP_DSTEP,
    OP_MOVE, OP_TRANS, OP_FINAL
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_TURN, S_YAW_PREP, S_YAW_MOD, S_PITCH, S_C_INIT, S_C_ITER,
    S_C_DONE, S_PROD, S_SPEED, S_DSTEP, S_MOVE, S_TRANS, S_FINAL, S_OUT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] step;
    logic [1:0] comp;
  } dp_cmd_t;

  // input beat, last field in the low bits
  typedef struct packed {
    logic [7:0]  turbo_factor;
    logic        move_right;
    logic        move_left;
    logic        move_backward;
    logic        move_forward;
    logic        first_frame;
    logic [15:0] frame_time;
    logic [11:0] mouse_y;
    logic [11:0] mouse_x;
  } in_item_t;

  // result beat, last field in the low bits
  typedef struct packed {
    logic signed [47:0] trans_z;
    logic signed [47:0] trans_y;
    logic signed [47:0] trans_x;
    logic signed [15:0] neg_fwd_z;
    logic signed [15:0] neg_fwd_y;
    logic signed [15:0] neg_fwd_x;
    logic signed [15:0] up_z;
    logic signed [15:0] up_y;
    logic signed [15:0] up_x;
    logic signed [15:0] right_z;
    logic signed [15:0] right_x;
  } result_t;

  function automatic logic [22:0] atan_lut(input logic [3:0] i);
    logic [22:0] v;
    case (i)
      4'd0:    v = 23'd2949120;
      4'd1:    v = 23'd1740967;
      4'd2:    v = 23'd919879;
      4'd3:    v = 23'd466945;
      4'd4:    v = 23'd234379;
      4'd5:    v = 23'd117304;
      4'd6:    v = 23'd58666;
      4'd7:    v = 23'd29335;
      4'd8:    v = 23'd14668;
      4'd9:    v = 23'd7334;
      4'd10:   v = 23'd3667;
      4'd11:   v = 23'd1833;
      4'd12:   v = 23'd917;
      4'd13:   v = 23'd458;
      4'd14:   v = 23'd229;
      default: v = 23'd115;
    endcase
    return v;
  endfunction

  // integer part of the speed in units per second
  function automatic logic [25:0] speed_int(input logic [3:0] lvl, input logic space);
    logic [25:0] v;
    if (space) begin
      case (lvl)
        4'd0:    v = 26'd200;
        4'd1:    v = 26'd4000;
        4'd2:    v = 26'd8000;
        4'd3:    v = 26'd16000;
        4'd4:    v = 26'd64000;
        4'd5:    v = 26'd256000;
        4'd6:    v = 26'd1024000;
        4'd7:    v = 26'd4096000;
        4'd8:    v = 26'd16384000;
        4'd9:    v = 26'd64384000;
        default: v = 26'd8000;
      endcase
    end else begin
      case (lvl)
        4'd0:    v = 26'd0;
        4'd1:    v = 26'd1;
        4'd2:    v = 26'd2;
        4'd3:    v = 26'd4;
        4'd4:    v = 26'd8;
        4'd5:    v = 26'd16;
        4'd6:    v = 26'd32;
        4'd7:    v = 26'd64;
        4'd8:    v = 26'd128;
        4'd9:    v = 26'd256;
        default: v = 26'd1;
      endcase
    end
    return v;
  endfunction

  // fractional part, Q0.16; only the slowest ground speed has one
  function automatic logic [12:0] speed_frac(input logic [3:0] lvl, input logic space);
    return (!space && lvl == 4'd0) ? 13'd6554 : 13'd0;
  endfunction

endpackage

/* sv/fcvu_ctrl.sv */
// Sequencer for the camera view update: steps the datapath through one frame.
// Depends on fcvu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fcvu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_free_i,
  output logic               out_load_o,
  output fcvu_pkg::dp_cmd_t  cmd_o
);

  fcvu_pkg::ctl_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic       sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcvu_pkg::S_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      sel_q   <= sel_d;
    end
  end

  // next state and counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    sel_d   = sel_q;
    case (state_q)
      fcvu_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fcvu_pkg::S_TURN;
      end
      fcvu_pkg::S_TURN: state_d = fcvu_pkg::S_YAW_PREP;
      fcvu_pkg::S_YAW_PREP: begin
        state_d = fcvu_pkg::S_YAW_MOD;
        cnt_d   = fcvu_pkg::YAW_MOD_TOP;
      end
      fcvu_pkg::S_YAW_MOD: begin
        if (cnt_q == '0) state_d = fcvu_pkg::S_PITCH;
        else cnt_d = cnt_q - 4'd1;
      end
      fcvu_pkg::S_PITCH: begin
        state_d = fcvu_pkg::S_C_INIT;
        sel_d   = 1'b0;
      end
      fcvu_pkg::S_C_INIT: begin
        state_d = fcvu_pkg::S_C_ITER;
        cnt_d   = '0;
      end
      fcvu_pkg::S_C_ITER: begin
        if (cnt_q == fcvu_pkg::CORDIC_LAST) state_d = fcvu_pkg::S_C_DONE;
        else cnt_d = cnt_q + 4'd1;
      end
      fcvu_pkg::S_C_DONE: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = fcvu_pkg::S_C_INIT;
        end else begin
          state_d = fcvu_pkg::S_PROD;
          cnt_d   = '0;
        end
      end
      fcvu_pkg::S_PROD: begin
        if (cnt_q == 4'd3) state_d = fcvu_pkg::S_SPEED;
        else cnt_d = cnt_q + 4'd1;
      end
      fcvu_pkg::S_SPEED: state_d = fcvu_pkg::S_DSTEP;
      fcvu_pkg::S_DSTEP: begin
        state_d = fcvu_pkg::S_MOVE;
        cnt_d   = '0;
        comp_d  = '0;
      end
      fcvu_pkg::S_MOVE: begin
        if (comp_q == 2'd2) begin
          comp_d = '0;
          if (cnt_q == 4'd3) begin
            state_d = fcvu_pkg::S_TRANS;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      fcvu_pkg::S_TRANS: begin
        if (comp_q == 2'd2) begin
          comp_d = '0;
          if (cnt_q == 4'd2) begin
            state_d = fcvu_pkg::S_FINAL;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      fcvu_pkg::S_FINAL: begin
        if (cnt_q == 4'd2) state_d = fcvu_pkg::S_OUT;
        else cnt_d = cnt_q + 4'd1;
      end
      fcvu_pkg::S_OUT: begin
        if (out_free_i) state_d = fcvu_pkg::S_IDLE;
      end
      default: state_d = fcvu_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o   = 1'b0;
    out_load_o   = 1'b0;
    cmd_o.op     = fcvu_pkg::OP_NONE;
    cmd_o.step   = cnt_q;
    cmd_o.comp   = comp_q;
    case (state_q)
      fcvu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = fcvu_pkg::OP_CAPTURE;
      end
      fcvu_pkg::S_TURN:     cmd_o.op = fcvu_pkg::OP_TURN;
      fcvu_pkg::S_YAW_PREP: cmd_o.op = fcvu_pkg::OP_YAW_PREP;
      fcvu_pkg::S_YAW_MOD:  cmd_o.op = fcvu_pkg::OP_YAW_MOD;
      fcvu_pkg::S_PITCH:    cmd_o.op = fcvu_pkg::OP_PITCH;
      fcvu_pkg::S_C_INIT: begin
        cmd_o.op   = fcvu_pkg::OP_C_INIT;
        cmd_o.comp = {1'b0, sel_q};
      end
      fcvu_pkg::S_C_ITER:   cmd_o.op = fcvu_pkg::OP_C_ITER;
      fcvu_pkg::S_C_DONE: begin
        cmd_o.op   = fcvu_pkg::OP_C_DONE;
        cmd_o.comp = {1'b0, sel_q};
      end
      fcvu_pkg::S_PROD:     cmd_o.op = fcvu_pkg::OP_PROD;
      fcvu_pkg::S_SPEED:    cmd_o.op = fcvu_pkg::OP_SPEED;
      fcvu_pkg::S_DSTEP:    cmd_o.op = fcvu_pkg::OP_DSTEP;
      fcvu_pkg::S_MOVE:     cmd_o.op = fcvu_pkg::OP_MOVE;
      fcvu_pkg::S_TRANS:    cmd_o.op = fcvu_pkg::OP_TRANS;
      fcvu_pkg::S_FINAL:    cmd_o.op = fcvu_pkg::OP_FINAL;
      fcvu_pkg::S_OUT:      out_load_o = out_free_i;
      default:              cmd_o.op = fcvu_pkg::OP_NONE;
    endcase
  end

  `ASSERT_AT(a_accept_starts, (in_valid_i && in_ready_o) |=> state_q == fcvu_pkg::S_TURN)
  `ASSERT_NEVER(a_load_while_ready, in_ready_o && out_load_o)
  `ASSERT_AT(a_load_to_idle, out_load_o |=> state_q == fcvu_pkg::S_IDLE)
endmodule

/* sv/fcvu_datapath.sv */
// Datapath of the camera view update: angle update, shared CORDIC, serial products,
// position stepping and translation. Depends on fcvu_pkg.
`timescale 1ns / 1ps
module fcvu_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcvu_pkg::dp_cmd_t   cmd_i,
  input  fcvu_pkg::in_item_t  item_i,
  input  logic [3:0]          speed_level_i,
  input  logic                space_mode_i,
  input  logic [10:0]         center_x_i,
  input  logic [10:0]         center_y_i,
  output fcvu_pkg::result_t   result_o
);

  function automatic logic signed [15:0] q14_of_prod(input logic signed [63:0] p);
    logic signed [64:0] a;
    logic signed [34:0] t;
    logic signed [35:0] u;
    a = 65'(p) + 65'sd536870912;
    t = 35'(a >>> 30);
    u = 36'(t) + 36'sd32768;
    return 16'(u >>> 16);
  endfunction

  function automatic logic signed [15:0] q14_of_q30(input logic signed [31:0] v);
    logic signed [32:0] a;
    a = 33'(v) + 33'sd32768;
    return 16'(a >>> 16);
  endfunction

  fcvu_pkg::in_item_t item_q;
  logic signed [35:0] turn_y_q, turn_p_q;
  logic signed [36:0] r_q;
  logic signed [25:0] yaw_q, pitch_q;
  logic signed [47:0] pos_q [3];
  logic signed [33:0] x_q, y_q;
  logic signed [25:0] z_q;
  logic               neg_q;
  logic signed [31:0] cosy_q, siny_q, cosp_q, sinp_q;
  logic signed [15:0] fwd_q [3];
  logic signed [15:0] rgt_q [3];
  logic signed [15:0] up_q [3];
  logic        [41:0] base_q;
  logic        [49:0] d_q;
  logic signed [65:0] acc_q [3];
  logic signed [47:0] trans_q [3];

  // turn
  logic signed [13:0] dx, dy;
  logic signed [16:0] ft_s;
  logic signed [30:0] dxft, dyft;
  assign dx   = item_q.first_frame ? 14'sd0 : $signed({2'b0, item_q.mouse_x} - {3'b0, center_x_i});
  assign dy   = item_q.first_frame ? 14'sd0 : $signed({3'b0, center_y_i} - {2'b0, item_q.mouse_y});
  assign ft_s = $signed({1'b0, item_q.frame_time});
  assign dxft = dx * ft_s;
  assign dyft = dy * ft_s;

  // yaw wrap
  logic signed [36:0] r_pre, r_sub;
  assign r_pre = 37'(yaw_q) + 37'(turn_y_q) + fcvu_pkg::YAW_BIAS;
  assign r_sub = fcvu_pkg::DEG_360_W <<< cmd_i.step;

  logic signed [35:0] p_sum;
  assign p_sum = 36'(pitch_q) + turn_p_q;

  // CORDIC
  logic signed [25:0] c_ang, c_at;
  logic signed [33:0] xs, ys;
  assign c_ang = cmd_i.comp[0] ? pitch_q : yaw_q;
  assign c_at  = $signed({3'b0, fcvu_pkg::atan_lut(cmd_i.step)});
  assign xs    = x_q >>> cmd_i.step;
  assign ys    = y_q >>> cmd_i.step;
  logic signed [33:0] x_out, y_out;
  assign x_out = neg_q ? -x_q : x_q;
  assign y_out = neg_q ? -y_q : y_q;

  // shared product multiplier
  logic signed [31:0] pa, pb;
  logic signed [63:0] pp;
  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    begin pa = cosp_q; pb = cosy_q; end
      2'd1:    begin pa = cosp_q; pb = siny_q; end
      2'd2:    begin pa = sinp_q; pb = cosy_q; end
      default: begin pa = sinp_q; pb = siny_q; end
    endcase
  end
  assign pp = pa * pb;

  // speed
  logic [25:0] sp_int;
  logic [12:0] sp_frac;
  logic [41:0] base_int;
  logic [29:0] base_fr;
  assign sp_int   = fcvu_pkg::speed_int(speed_level_i, space_mode_i);
  assign sp_frac  = fcvu_pkg::speed_frac(speed_level_i, space_mode_i);
  assign base_int = 42'(sp_int) * 42'(item_q.frame_time);
  assign base_fr  = 30'(sp_frac) * 30'(item_q.frame_time) + 30'd32768;

  // key stepping
  logic [3:0]         keys;
  logic [1:0]         key;
  logic signed [15:0] mv;
  logic [14:0]        mag;
  logic [50:0]        q_hi;
  logic [29:0]        q_lo;
  logic [51:0]        q;
  logic               sub;
  logic signed [53:0] mv_sum, mv_sat;
  assign keys   = {item_q.move_right, item_q.move_left, item_q.move_backward,
                   item_q.move_forward};
  assign key    = cmd_i.step[1:0];
  assign mv     = key[1] ? rgt_q[cmd_i.comp] : fwd_q[cmd_i.comp];
  assign mag    = mv[15] ? 15'(-mv) : mv[14:0];
  assign q_hi   = 51'(d_q[49:14]) * 51'(mag);
  assign q_lo   = 30'(d_q[13:0]) * 30'(mag) + 30'd8192;
  assign q      = 52'(q_hi) + 52'(q_lo[29:14]);
  // forward and right add along the vector, backward and left subtract
  assign sub    = mv[15] ^ (key == 2'd1 || key == 2'd2);
  assign mv_sum = sub ? 54'(pos_q[cmd_i.comp]) - $signed({2'b0, q})
                      : 54'(pos_q[cmd_i.comp]) + $signed({2'b0, q});
  assign mv_sat = (mv_sum > fcvu_pkg::POS_MAX) ? fcvu_pkg::POS_MAX :
                  (mv_sum < fcvu_pkg::POS_MIN) ? fcvu_pkg::POS_MIN : mv_sum;

  // translation
  logic signed [15:0] tv;
  logic signed [63:0] tp;
  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    tv = rgt_q[cmd_i.comp];
      2'd1:    tv = up_q[cmd_i.comp];
      default: tv = fwd_q[cmd_i.comp];
    endcase
  end
  assign tp = tv * pos_q[cmd_i.comp];

  logic signed [66:0] fa;
  logic signed [53:0] fr, fn, fs;
  assign fa = 67'(acc_q[cmd_i.step[1:0]]) + 67'sd8192;
  assign fr = 54'(fa >>> 14);
  assign fn = (cmd_i.step[1:0] == 2'd2) ? fr : -fr;
  assign fs = (fn > fcvu_pkg::POS_MAX) ? fcvu_pkg::POS_MAX :
              (fn < fcvu_pkg::POS_MIN) ? fcvu_pkg::POS_MIN : fn;

  // camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= fcvu_pkg::YAW_RESET;
      pitch_q <= '0;
      for (int k = 0; k < 3; k++) pos_q[k] <= '0;
    end else begin
      case (cmd_i.op)
        fcvu_pkg::OP_PITCH: begin
          yaw_q <= 26'(r_q - fcvu_pkg::YAW_BIAS);
          if (p_sum > fcvu_pkg::PITCH_MAX) pitch_q <= 26'(fcvu_pkg::PITCH_MAX);
          else if (p_sum < -fcvu_pkg::PITCH_MAX) pitch_q <= 26'(-fcvu_pkg::PITCH_MAX);
          else pitch_q <= 26'(p_sum);
        end
        fcvu_pkg::OP_MOVE: begin
          if (keys[key]) pos_q[cmd_i.comp] <= 48'(mv_sat);
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fcvu_pkg::OP_CAPTURE: item_q <= item_i;
      fcvu_pkg::OP_TURN: begin
        turn_y_q <= (36'(dxft) <<< 4) + 36'(dxft);
        turn_p_q <= (36'(dyft) <<< 4) + 36'(dyft);
      end
      fcvu_pkg::OP_YAW_PREP: r_q <= (r_pre < 0) ? r_pre + fcvu_pkg::DEG_360_K : r_pre;
      fcvu_pkg::OP_YAW_MOD: begin
        if (r_q >= r_sub) r_q <= r_q - r_sub;
      end
      fcvu_pkg::OP_C_INIT: begin
        x_q <= fcvu_pkg::CORDIC_K;
        y_q <= '0;
        if (c_ang > fcvu_pkg::DEG_90) begin
          z_q <= c_ang - fcvu_pkg::DEG_180;
          neg_q <= 1'b1;
        end else if (c_ang < -fcvu_pkg::DEG_90) begin
          z_q <= c_ang + fcvu_pkg::DEG_180;
          neg_q <= 1'b1;
        end else begin
          z_q <= c_ang;
          neg_q <= 1'b0;
        end
      end
      fcvu_pkg::OP_C_ITER: begin
        if (!z_q[25]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - c_at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + c_at;
        end
      end
      fcvu_pkg::OP_C_DONE: begin
        if (cmd_i.comp[0]) begin
          cosp_q <= 32'(x_out);
          sinp_q <= 32'(y_out);
        end else begin
          cosy_q <= 32'(x_out);
          siny_q <= 32'(y_out);
        end
      end
      fcvu_pkg::OP_PROD: begin
        case (cmd_i.step[1:0])
          2'd0: begin
            fwd_q[0] <= q14_of_prod(pp);
            fwd_q[1] <= q14_of_q30(sinp_q);
            rgt_q[0] <= -q14_of_q30(siny_q);
            rgt_q[1] <= '0;
            rgt_q[2] <= q14_of_q30(cosy_q);
            up_q[1]  <= q14_of_q30(cosp_q);
          end
          2'd1:    fwd_q[2] <= q14_of_prod(pp);
          2'd2:    up_q[0]  <= -q14_of_prod(pp);
          default: up_q[2]  <= -q14_of_prod(pp);
        endcase
      end
      fcvu_pkg::OP_SPEED: base_q <= base_int + 42'(base_fr[29:16]);
      fcvu_pkg::OP_DSTEP: d_q <= 50'(base_q) * 50'(item_q.turbo_factor);
      fcvu_pkg::OP_TRANS: begin
        if (cmd_i.comp == 2'd0) acc_q[cmd_i.step[1:0]] <= 66'(tp);
        else acc_q[cmd_i.step[1:0]] <= acc_q[cmd_i.step[1:0]] + 66'(tp);
      end
      fcvu_pkg::OP_FINAL: trans_q[cmd_i.step[1:0]] <= 48'(fs);
      default: ;
    endcase
  end

  assign result_o.right_x   = rgt_q[0];
  assign result_o.right_z   = rgt_q[2];
  assign result_o.up_x      = up_q[0];
  assign result_o.up_y      = up_q[1];
  assign result_o.up_z      = up_q[2];
  assign result_o.neg_fwd_x = -fwd_q[0];
  assign result_o.neg_fwd_y = -fwd_q[1];
  assign result_o.neg_fwd_z = -fwd_q[2];
  assign result_o.trans_x   = trans_q[0];
  assign result_o.trans_y   = trans_q[1];
  assign result_o.trans_z   = trans_q[2];
endmodule

/* sv/fps_camera_view_update_core.sv */
// The result beat follows an accepted input beat through the 11 yaw-wrap steps,
//   two 16-step CORDIC runs and the serial multiplies.
// Frames are processed one at a time and a new beat is accepted only when idle; a waiting
//   result sits in the output register and the next beat is accepted after it loads.
// Reset: rst_ni async low; yaw -90 deg, pitch 0, position at the origin, config 0.
`timescale 1ns / 1ps
module fps_camera_view_update_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input beat, tdata low to high: mouse_x[11:0], mouse_y[23:12],
  // frame_time[39:24], first_frame[40], move_forward[41], move_backward[42],
  // move_left[43], move_right[44], turbo_factor[52:45], zero pad[55:53]
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [55:0]  s_axis_tdata_i,
  // result beat, tdata low to high: right_x, right_z, up_x, up_y, up_z,
  // neg_fwd_x, neg_fwd_y, neg_fwd_z (16 bits each), trans_x, trans_y, trans_z (48 each)
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [271:0] m_axis_tdata_o,
  // register writes: 0 speed_level, 1 space_mode, 2 center_x, 3 center_y
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [10:0]  cfg_data_i
);

  logic [3:0]  speed_level_q;
  logic        space_mode_q;
  logic [10:0] center_x_q, center_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_level_q <= '0;
      space_mode_q  <= 1'b0;
      center_x_q    <= '0;
      center_y_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcvu_pkg::CFG_SPEED_LEVEL: speed_level_q <= cfg_data_i[3:0];
        fcvu_pkg::CFG_SPACE_MODE:  space_mode_q  <= cfg_data_i[0];
        fcvu_pkg::CFG_CENTER_X:    center_x_q    <= cfg_data_i;
        fcvu_pkg::CFG_CENTER_Y:    center_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fcvu_pkg::dp_cmd_t cmd;
  fcvu_pkg::result_t result;
  logic out_load, out_free;

  // output register frees when empty or being drained this cycle
  logic out_valid_q;
  fcvu_pkg::result_t out_q;
  assign out_free = !out_valid_q || m_axis_tready_i;

  fcvu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  fcvu_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_i        (fcvu_pkg::in_item_t'(s_axis_tdata_i[52:0])),
    .speed_level_i (speed_level_q),
    .space_mode_i  (space_mode_q),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
endmodule
